### rtl/sd_card_spi_mode_controller_core_macros.svh
// Assertion helpers used by the controller core RTL
`ifndef SD_CARD_SPI_MODE_CONTROLLER_CORE_MACROS_SVH
`define SD_CARD_SPI_MODE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define SDC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sdc_pkg.sv
package sdc_pkg;

   localparam int unsigned SECTOR_BYTES = 512;
   localparam int unsigned CSD_BYTES    = 16;

   typedef enum logic [1:0] {
      REQ_INIT = 2'd0,
      REQ_READ = 2'd1,
      REQ_CAP  = 2'd2,
      REQ_BYTE = 2'd3
   } req_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_INIT = 2'd1,
      OP_READ = 2'd2,
      OP_CAP  = 2'd3
   } op_type;

   typedef enum logic [13:0] {
      PH_IDLE    = 14'b00000000000001,
      PH_CLK     = 14'b00000000000010,
      PH_DESEL   = 14'b00000000000100,
      PH_READY   = 14'b00000000001000,
      PH_SELFAIL = 14'b00000000010000,
      PH_GAP     = 14'b00000000100000,
      PH_CMD     = 14'b00000001000000,
      PH_POLL    = 14'b00000010000000,
      PH_REPLY   = 14'b00000100000000,
      PH_TOKEN   = 14'b00001000000000,
      PH_DATA    = 14'b00010000000000,
      PH_CRC     = 14'b00100000000000,
      PH_CSD     = 14'b01000000000000,
      PH_FINAL   = 14'b10000000000000
   } phase_type;

   // configuration register indexes
   localparam logic [2:0] CSR_READY_WAIT = 3'd0;
   localparam logic [2:0] CSR_RESP_POLLS = 3'd1;
   localparam logic [2:0] CSR_IDLE_TRIES = 3'd2;
   localparam logic [2:0] CSR_ACMD_TRIES = 3'd3;
   localparam logic [2:0] CSR_TOKEN_WAIT = 3'd4;

   // command indexes
   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD8  = 6'd8;
   localparam logic [5:0] CMD9  = 6'd9;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD41 = 6'd41;
   localparam logic [5:0] CMD55 = 6'd55;
   localparam logic [5:0] CMD58 = 6'd58;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_SD2  = 2'd1;
   localparam logic [1:0] KIND_SDHC = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   localparam logic [7:0] ST_OK      = 8'h00;
   localparam logic [7:0] ST_UNKNOWN = 8'haa;
   localparam logic [7:0] ST_SELFAIL = 8'hff;
   localparam logic [7:0] DATA_TOKEN = 8'hfe;
   localparam logic [7:0] IDLE_BYTE  = 8'hff;

   // build the 48-bit command frame
   function automatic logic [47:0] cmd_frame(input logic [5:0] idx, input logic [31:0] arg,
                                             input logic [7:0] crc);
      cmd_frame = {2'b01, idx, arg, crc};
   endfunction

   // sector count from CSD version 1 or 2
   function automatic logic [31:0] csd_sectors(input logic [7:0] b0, input logic [7:0] b5,
                                               input logic [7:0] b6, input logic [7:0] b7,
                                               input logic [7:0] b8, input logic [7:0] b9,
                                               input logic [7:0] b10);
      logic [22:0] c2;
      logic [12:0] c1;
      logic [4:0]  sh;
      logic [44:0] n1;
      c2 = {1'b0, b7[5:0], b8, b9} + 23'd1;
      c1 = {1'b0, b6[1:0], b7, b8[7:6]} + 13'd1;
      sh = 5'({b9[1:0], b10[7]}) + 5'd2 + 5'(b5[3:0]);
      n1 = 45'(c1) << sh;
      if (b0[7:6] == 2'b01) begin
         csd_sectors = c2[22] ? 32'hffffffff : {c2[21:0], 10'b0};
      end else begin
         csd_sectors = n1[40:9];
      end
   endfunction

endpackage

### rtl/sd_card_spi_mode_controller_core.sv
// SD card sequencer for SPI mode: bring-up, single-sector read, capacity read.
// Request channel (req_): tuser carries the request kind (init, read sector,
// read capacity, returned byte); tdata carries the sector number and the byte
// the card shifted back for the last transmitted byte.
// Result channel (rsp_): one result per request transfer. It names the next
// byte to exchange with its chip-select and clock-speed levels, a sector
// payload byte when one arrived (tlast on the 512th), and completion status,
// card type and capacity.
// The decision for an item is made in the cycle it is accepted and lands in the
// result register. One item is taken every cycle; the request side stalls only
// while the result register is full and the receiver holds rsp_tready low.
// csr_ writes set the wait and retry limits; they are taken at any time and
// should be issued while no request is in progress.
// Reset (synchronous, active high) returns the sequencer to idle, card type
// none, and restores the default limits.
module sd_card_spi_mode_controller_core #(
   parameter int unsigned INIT_CLOCK_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // sector[31:0], rx_byte[39:32]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // tx_byte, data_byte, status, capacity[55:24]
   output logic [6:0]  rsp_tuser,   // tx_valid, chip_select_high, slow_clock,
                                    // data_valid, done_res, card_type[6:5]
   output logic        rsp_tlast,   // data_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import sdc_pkg::*;

   // configuration
   logic [23:0] ready_wait_ff;
   logic [7:0]  resp_polls_ff, idle_tries_ff;
   logic [15:0] acmd_tries_ff, token_wait_ff;

   // sequencer state
   phase_type   phase_ff, phase_in;
   op_type      op_ff, op_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [23:0] wcnt_ff, wcnt_in;
   logic [15:0] rcnt_ff, rcnt_in;
   logic [47:0] cmd_ff, cmd_in;
   logic [7:0]  last_resp_ff, last_resp_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] psec_ff, psec_in;
   logic        sel_cmd_ff, sel_cmd_in;
   logic [7:0]  fin_st_ff, fin_st_in;
   logic [31:0] fin_cap_ff, fin_cap_in;
   logic [7:0]  reply_ff [4];
   logic [7:0]  csd_ff [CSD_BYTES];

   // result register
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic [6:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_acc;
   logic [1:0]  rq;
   logic [31:0] sector;
   logic [7:0]  rx;
   logic        done, dvalid, dlast;
   logic        reply_we, csd_we;
   logic [7:0]  txb;
   logic        csh;
   logic [5:0]  cmd_idx;
   logic        cmd_fin;
   logic [7:0]  cmd_r;

   assign rq      = req_tuser;
   assign sector  = req_tdata[31:0];
   assign rx      = req_tdata[39:32];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign cmd_idx = cmd_ff[45:40];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_wait_ff <= 24'hffffff;
         resp_polls_ff <= 8'd32;
         idle_tries_ff <= 8'd21;
         acmd_tries_ff <= 16'hffff;
         token_wait_ff <= 16'hfff;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_READY_WAIT: ready_wait_ff <= csr_data;
            CSR_RESP_POLLS: resp_polls_ff <= csr_data[7:0];
            CSR_IDLE_TRIES: idle_tries_ff <= csr_data[7:0];
            CSR_ACMD_TRIES: acmd_tries_ff <= csr_data[15:0];
            CSR_TOKEN_WAIT: token_wait_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // next-state decision for one item
   always_comb begin
      phase_in = phase_ff;  op_in = op_ff;  bcnt_in = bcnt_ff;  wcnt_in = wcnt_ff;
      rcnt_in = rcnt_ff;  cmd_in = cmd_ff;  last_resp_in = last_resp_ff;
      kind_in = kind_ff;  psec_in = psec_ff;  sel_cmd_in = sel_cmd_ff;
      fin_st_in = fin_st_ff;  fin_cap_in = fin_cap_ff;
      done = 1'b0;  dvalid = 1'b0;  dlast = 1'b0;
      reply_we = 1'b0;  csd_we = 1'b0;
      cmd_fin = 1'b0;  cmd_r = rx;

      unique case (rq)
         REQ_INIT: begin
            op_in = OP_INIT;  kind_in = KIND_NONE;  phase_in = PH_CLK;  bcnt_in = '0;
         end
         REQ_READ: begin
            op_in = OP_READ;  psec_in = sector;  sel_cmd_in = 1'b0;  phase_in = PH_DESEL;
         end
         REQ_CAP: begin
            op_in = OP_CAP;  cmd_in = cmd_frame(CMD9, '0, 8'hff);
            sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
         end
         default: begin
            unique case (phase_ff)
               PH_CLK: begin
                  bcnt_in = bcnt_ff + 10'd1;
                  if (bcnt_in >= 10'(INIT_CLOCK_BYTES)) begin
                     rcnt_in = '0;  cmd_in = cmd_frame(CMD0, '0, 8'h95);
                     sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                  end
               end
               PH_DESEL: begin
                  phase_in = PH_READY;  wcnt_in = '0;
               end
               PH_READY: begin
                  if (rx == IDLE_BYTE) begin
                     if (sel_cmd_ff) begin
                        phase_in = PH_GAP;  bcnt_in = '0;
                     end else begin
                        cmd_in = cmd_frame(CMD17, (kind_ff == KIND_SDHC) ? psec_ff
                                           : {psec_ff[22:0], 9'b0}, 8'h01);
                        sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                     end
                  end else begin
                     wcnt_in = wcnt_ff + 24'd1;
                     if (wcnt_in >= ready_wait_ff) phase_in = PH_SELFAIL;
                  end
               end
               PH_SELFAIL: begin
                  if (sel_cmd_ff) begin
                     cmd_fin = 1'b1;  cmd_r = ST_SELFAIL;
                  end else begin
                     phase_in = PH_IDLE;  op_in = OP_NONE;  done = 1'b1;
                     fin_st_in = ST_SELFAIL;  fin_cap_in = '0;
                  end
               end
               PH_GAP: begin
                  bcnt_in = bcnt_ff + 10'd1;
                  if (bcnt_in >= 10'd3) begin
                     phase_in = PH_CMD;  bcnt_in = '0;
                  end
               end
               PH_CMD: begin
                  bcnt_in = bcnt_ff + 10'd1;
                  if (bcnt_in >= 10'd6) begin
                     phase_in = PH_POLL;  bcnt_in = '0;
                  end
               end
               PH_POLL: begin
                  bcnt_in = bcnt_ff + 10'd1;
                  if (!(rx[7] && (bcnt_in < 10'(resp_polls_ff)))) cmd_fin = 1'b1;
               end
               PH_REPLY: begin
                  reply_we = 1'b1;
                  bcnt_in = bcnt_ff + 10'd1;
                  if (bcnt_in >= 10'd4) begin
                     if (cmd_idx == CMD8) begin
                        if (reply_ff[2] == 8'h01 && rx == 8'haa) begin
                           rcnt_in = '0;  cmd_in = cmd_frame(CMD55, '0, 8'h01);
                           sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                        end else begin
                           phase_in = PH_FINAL;
                        end
                     end else begin
                        kind_in = reply_ff[0][6] ? KIND_SDHC : KIND_SD2;
                        phase_in = PH_FINAL;
                     end
                  end
               end
               PH_TOKEN: begin
                  if (rx == DATA_TOKEN) begin
                     phase_in = (op_ff == OP_CAP) ? PH_CSD : PH_DATA;  bcnt_in = '0;
                  end else begin
                     wcnt_in = wcnt_ff + 24'd1;
                     if (wcnt_in >= 24'(token_wait_ff)) begin
                        fin_st_in = ST_UNKNOWN;  fin_cap_in = '0;
                        if (op_ff == OP_CAP) begin
                           phase_in = PH_IDLE;  op_in = OP_NONE;  done = 1'b1;
                        end else begin
                           phase_in = PH_FINAL;
                        end
                     end
                  end
               end
               PH_DATA: begin
                  dvalid = 1'b1;
                  dlast = (bcnt_ff == 10'(SECTOR_BYTES - 1));
                  bcnt_in = bcnt_ff + 10'd1;
                  if (dlast) begin
                     phase_in = PH_CRC;  bcnt_in = '0;
                  end
               end
               PH_CSD: begin
                  csd_we = 1'b1;
                  bcnt_in = bcnt_ff + 10'd1;
                  if (bcnt_in >= 10'(CSD_BYTES)) begin
                     phase_in = PH_CRC;  bcnt_in = '0;
                  end
               end
               PH_CRC: begin
                  bcnt_in = bcnt_ff + 10'd1;
                  if (bcnt_in >= 10'd2) begin
                     fin_st_in = ST_OK;
                     fin_cap_in = (op_ff == OP_CAP) ? csd_sectors(csd_ff[0], csd_ff[5],
                                  csd_ff[6], csd_ff[7], csd_ff[8], csd_ff[9], csd_ff[10])
                                  : '0;
                     phase_in = PH_FINAL;
                  end
               end
               PH_FINAL: begin
                  phase_in = PH_IDLE;  op_in = OP_NONE;  done = 1'b1;
               end
               default: ;
            endcase

            // command response handling
            if (cmd_fin) begin
               case (cmd_idx)
                  CMD0: begin
                     last_resp_in = cmd_r;
                     if (cmd_r == 8'h01) begin
                        cmd_in = cmd_frame(CMD8, 32'h1aa, 8'h87);
                        sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                     end else begin
                        rcnt_in = rcnt_ff + 16'd1;
                        if (rcnt_in < 16'(idle_tries_ff)) begin
                           cmd_in = cmd_frame(CMD0, '0, 8'h95);
                           sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                        end else begin
                           phase_in = PH_FINAL;
                        end
                     end
                  end
                  CMD8: begin
                     if (cmd_r == 8'h01) begin
                        phase_in = PH_REPLY;  bcnt_in = '0;
                     end else begin
                        phase_in = PH_FINAL;
                     end
                  end
                  CMD55: begin
                     cmd_in = cmd_frame(CMD41, 32'h40000000, 8'h01);
                     sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                  end
                  CMD41: begin
                     last_resp_in = cmd_r;
                     if (cmd_r == 8'h00) begin
                        cmd_in = cmd_frame(CMD58, '0, 8'h01);
                        sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                     end else begin
                        rcnt_in = rcnt_ff + 16'd1;
                        if (rcnt_in < acmd_tries_ff) begin
                           cmd_in = cmd_frame(CMD55, '0, 8'h01);
                           sel_cmd_in = 1'b1;  phase_in = PH_DESEL;
                        end else begin
                           kind_in = KIND_ERR;  phase_in = PH_FINAL;
                        end
                     end
                  end
                  CMD58: begin
                     if (cmd_r == 8'h00) begin
                        phase_in = PH_REPLY;  bcnt_in = '0;
                     end else begin
                        kind_in = KIND_ERR;  phase_in = PH_FINAL;
                     end
                  end
                  CMD17: begin
                     last_resp_in = cmd_r;
                     if (cmd_r == 8'h00) begin
                        phase_in = PH_TOKEN;  wcnt_in = '0;
                     end else begin
                        fin_st_in = cmd_r;  fin_cap_in = '0;  phase_in = PH_FINAL;
                     end
                  end
                  CMD9: begin
                     if (cmd_r == 8'h00) begin
                        phase_in = PH_TOKEN;  wcnt_in = '0;
                     end else begin
                        phase_in = PH_IDLE;  op_in = OP_NONE;  done = 1'b1;
                        fin_st_in = cmd_r;  fin_cap_in = '0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;  op_in = OP_NONE;  done = 1'b1;
                     fin_st_in = cmd_r;  fin_cap_in = '0;
                  end
               endcase
            end

            // bring-up end: status from card type or last response, else unknown
            if (phase_in == PH_FINAL && phase_ff != PH_FINAL && op_ff == OP_INIT) begin
               if (kind_in != KIND_NONE)      fin_st_in = ST_OK;
               else if (last_resp_in != 8'h00) fin_st_in = last_resp_in;
               else                           fin_st_in = ST_UNKNOWN;
               fin_cap_in = '0;
            end
         end
      endcase
   end

   // next byte to exchange
   always_comb begin
      txb = 8'h00;
      csh = 1'b1;
      if (phase_in != PH_IDLE) begin
         txb = IDLE_BYTE;
         unique case (phase_in)
            PH_CLK, PH_DESEL, PH_SELFAIL, PH_GAP, PH_FINAL: csh = 1'b1;
            PH_CMD: begin
               csh = 1'b0;
               case (bcnt_in[2:0])
                  3'd0:    txb = cmd_in[47:40];
                  3'd1:    txb = cmd_in[39:32];
                  3'd2:    txb = cmd_in[31:24];
                  3'd3:    txb = cmd_in[23:16];
                  3'd4:    txb = cmd_in[15:8];
                  default: txb = cmd_in[7:0];
               endcase
            end
            default: csh = 1'b0;
         endcase
      end
      rsp_data_in = {done ? fin_cap_in : 32'd0, done ? fin_st_in : 8'd0,
                     dvalid ? rx : 8'd0, txb};
      rsp_user_in = {kind_in, done, dvalid, (phase_in != PH_IDLE) && (op_in == OP_INIT),
                     csh, phase_in != PH_IDLE};
      rsp_last_in = dlast;
   end

   // state update on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;  op_ff <= OP_NONE;  bcnt_ff <= '0;  wcnt_ff <= '0;
         rcnt_ff <= '0;  cmd_ff <= '0;  last_resp_ff <= 8'hff;  kind_ff <= KIND_NONE;
         psec_ff <= '0;  sel_cmd_ff <= 1'b0;  fin_st_ff <= '0;  fin_cap_ff <= '0;
      end else if (req_acc) begin
         phase_ff <= phase_in;  op_ff <= op_in;  bcnt_ff <= bcnt_in;  wcnt_ff <= wcnt_in;
         rcnt_ff <= rcnt_in;  cmd_ff <= cmd_in;  last_resp_ff <= last_resp_in;
         kind_ff <= kind_in;  psec_ff <= psec_in;  sel_cmd_ff <= sel_cmd_in;
         fin_st_ff <= fin_st_in;  fin_cap_ff <= fin_cap_in;
      end
   end

   // capture reply and CSD bytes
   always_ff @(posedge clock) begin
      if (req_acc && reply_we) reply_ff[bcnt_ff[1:0]] <= rx;
      if (req_acc && csd_we)   csd_ff[bcnt_ff[3:0]] <= rx;
   end

   // result register: load on request transfer, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "sd_card_spi_mode_controller_core_macros.svh"

   `SDC_ASSERT_NEXT(a_result_follows, req_acc, rsp_valid_ff, "no result after request")
   `SDC_ASSERT_NOW(a_done_idle, rsp_valid_ff && rsp_user_ff[4], !rsp_user_ff[0], "done while active")
   `SDC_ASSERT_NOW(a_data_active, rsp_valid_ff && rsp_user_ff[3], rsp_user_ff[0], "data while idle")
   `SDC_ASSERT_NOW(a_last_data, rsp_valid_ff && rsp_last_ff, rsp_user_ff[3], "last without data")

endmodule
